// ===== rtl/core/rfps_pkg.sv =====
`default_nettype none

package rfps_pkg;

  // Sizing of the piece stores
  localparam int MAX_PIECES  = 4096;
  localparam int COUNT_BITS  = 16;
  localparam int LANES       = 8;
  localparam int ROWS        = MAX_PIECES / LANES;
  localparam int ROW_BITS    = $clog2(ROWS);
  localparam int PIECE_BITS  = 12;
  localparam int NUM_BITS    = 13;
  localparam int BEST_BITS   = COUNT_BITS + 1;
  localparam int CNT_ROW_W   = LANES * COUNT_BITS;
  localparam int PS_BITS     = 2;
  localparam int ST_ROW_W    = LANES * PS_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP  = '1;
  localparam logic [BEST_BITS-1:0]  BEST_RESET = '1;
  localparam logic [NUM_BITS-1:0]   MAX_NUM    = NUM_BITS'(MAX_PIECES);

  // Register map: bit 2 of the byte address picks the register
  localparam logic REG_PIECE_COUNT = 1'b0;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_SELECT  = 3'd2,
    OP_RELEASE = 3'd3,
    OP_DONE    = 3'd4,
    OP_CORRUPT = 3'd5
  } opcode_t;

  typedef enum logic [PS_BITS-1:0] {
    PS_MISSING  = 2'd0,
    PS_PROGRESS = 2'd1,
    PS_COMPLETE = 2'd2
  } pstate_t;

  typedef enum logic [1:0] {
    RES_ACK    = 2'd0,
    RES_CHOSEN = 2'd1,
    RES_NONE   = 2'd2
  } result_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC,
    FSM_CLAIM
  } fsm_t;

  // Running best of a select sweep
  typedef struct packed {
    logic                  found;
    logic [BEST_BITS-1:0]  cnt;
    logic [PIECE_BITS-1:0] piece;
  } best_t;

endpackage

`default_nettype wire

// ===== rtl/core/rfps_row_unit.sv =====
`default_nettype none

// Eight-lane datapath for one memory row: count update for add/remove,
// rarest-first compare chain for select.
module rfps_row_unit (
  input  var rfps_pkg::opcode_t                 op,
  input  var logic [rfps_pkg::ROW_BITS-1:0]     row,
  input  var logic [7:0]                        bits,
  input  var logic [rfps_pkg::NUM_BITS-1:0]     n_use,
  input  var logic [rfps_pkg::CNT_ROW_W-1:0]    cnt_row,
  input  var logic [rfps_pkg::ST_ROW_W-1:0]     st_row,
  input  var rfps_pkg::best_t                   best_in,
  output var logic [rfps_pkg::CNT_ROW_W-1:0]    cnt_row_nxt,
  output var rfps_pkg::best_t                   best_out
);
  import rfps_pkg::*;

  logic [COUNT_BITS-1:0] c;
  logic [PS_BITS-1:0]    s;
  logic [PIECE_BITS-1:0] p;
  logic                  hit;

  // Lane 0 is the MSB of the byte and the lowest piece; the compare chain
  // runs in piece order so the first of equal counts wins.
  always_comb begin
    cnt_row_nxt = cnt_row;
    best_out    = best_in;
    c           = '0;
    s           = '0;
    p           = '0;
    hit         = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      c   = cnt_row[l*COUNT_BITS +: COUNT_BITS];
      s   = st_row[l*PS_BITS +: PS_BITS];
      p   = {PIECE_BITS'(row) << 3} | PIECE_BITS'(l);
      hit = bits[LANES-1-l] && ({1'b0, p} < n_use);
      if (hit) begin
        case (op)
          OP_ADD: begin
            if (c != COUNT_TOP) cnt_row_nxt[l*COUNT_BITS +: COUNT_BITS] = c + 1'b1;
          end
          OP_REMOVE: begin
            if (c != '0) cnt_row_nxt[l*COUNT_BITS +: COUNT_BITS] = c - 1'b1;
          end
          OP_SELECT: begin
            if (s == PS_MISSING && (!best_out.found || {1'b0, c} < best_out.cnt)) begin
              best_out.found = 1'b1;
              best_out.cnt   = {1'b0, c};
              best_out.piece = p;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rarest_first_piece_selector.sv =====
`default_nettype none

// Rarest-first piece selector.
// Commands enter on start/in_* and are taken when start is high and busy is
// low. Every command yields one result: out_strobe is high for one cycle with
// out_status, out_chosen_piece, out_pieces_remaining and out_all_done. The
// receiver has no back-pressure; each result must be taken in its cycle.
// Per-piece counts (16 bits) and piece states live in two row-wide memories,
// eight pieces to a row, one read-modify-write per command.
// At the accepting edge the command's row is read from both memories into
// registers; in the exec state it is modified and written back, and busy stays
// high, so no new command is taken before that write-back. The last byte of a
// select also reads the winner's state row and claims the winner in the claim
// state. The result strobe is registered from the exec state, or from the claim
// state for a final select byte.
// After reset the block runs a clearing pass over all 512 rows with busy high;
// APB writes to piece_count are taken during it. piece_count resets to 1 and
// may only be written while no command is in flight.
module rarest_first_piece_selector (
  input  var logic                              clk,
  input  var logic                              rst_n,
  // command channel
  input  var logic                              start,
  output var logic                              busy,
  input  var logic [2:0]                        in_opcode,
  input  var logic [8:0]                        in_byte_index,
  input  var logic [7:0]                        in_bitfield_byte,
  input  var logic                              in_last_byte,
  input  var logic [rfps_pkg::PIECE_BITS-1:0]   in_piece_index,
  // result channel
  output var logic                              out_strobe,
  output var logic [1:0]                        out_status,
  output var logic [rfps_pkg::PIECE_BITS-1:0]   out_chosen_piece,
  output var logic [rfps_pkg::NUM_BITS-1:0]     out_pieces_remaining,
  output var logic                              out_all_done,
  // APB configuration
  input  var logic                              psel,
  input  var logic                              penable,
  input  var logic                              pwrite,
  input  var logic [2:0]                        paddr,
  input  var logic [31:0]                       pwdata,
  output var logic [31:0]                       prdata,
  output var logic                              pready
);
  import rfps_pkg::*;

  localparam best_t BEST_CLR = '{found: 1'b0, cnt: BEST_RESET, piece: '0};

  // Storage
  logic [CNT_ROW_W-1:0] cnt_mem [ROWS];
  logic [ST_ROW_W-1:0]  st_mem  [ROWS];
  logic [CNT_ROW_W-1:0] cnt_rd_r;
  logic [ST_ROW_W-1:0]  st_rd_r;

  fsm_t                  fsm_r, fsm_nxt;
  logic [ROW_BITS-1:0]   clr_r, clr_nxt;
  opcode_t               op_r;
  logic [ROW_BITS-1:0]   row_r;
  logic [7:0]            bits_r;
  logic                  last_r;
  logic [PIECE_BITS-1:0] pidx_r;
  best_t                 best_r, best_nxt;
  logic [NUM_BITS-1:0]   ct_r, ct_nxt;
  logic [NUM_BITS-1:0]   pcnt_r;
  logic                  out_strobe_r;
  logic [1:0]            out_status_r;
  logic [PIECE_BITS-1:0] out_chosen_r;
  logic [NUM_BITS-1:0]   out_rem_r;
  logic                  out_done_r;

  logic                  accept;
  logic [NUM_BITS-1:0]   n_use;
  logic                  rd_en;
  logic [ROW_BITS-1:0]   rd_addr;
  logic [ROW_BITS-1:0]   wr_addr;
  logic                  cnt_we, st_we;
  logic [CNT_ROW_W-1:0]  cnt_wdata;
  logic [ST_ROW_W-1:0]   st_wdata;
  logic [CNT_ROW_W-1:0]  cnt_upd;
  best_t                 scan;
  logic                  res_valid;
  result_t               res_status;
  logic [PIECE_BITS-1:0] res_chosen;
  logic [NUM_BITS-1:0]   res_rem;
  logic [2:0]            lane;
  logic [PS_BITS-1:0]    ps_old;
  logic                  pidx_use;

  assign accept = start && (fsm_r == FSM_IDLE);
  assign busy   = (fsm_r != FSM_IDLE);
  assign n_use  = (pcnt_r > MAX_NUM) ? MAX_NUM : pcnt_r;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PIECE_COUNT) ? 32'(pcnt_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= NUM_BITS'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIECE_COUNT) begin
      pcnt_r <= pwdata[NUM_BITS-1:0];
    end
  end

  // Row datapath
  rfps_row_unit u_row (
    .op          (op_r),
    .row         (row_r),
    .bits        (bits_r),
    .n_use       (n_use),
    .cnt_row     (cnt_rd_r),
    .st_row      (st_rd_r),
    .best_in     (best_r),
    .cnt_row_nxt (cnt_upd),
    .best_out    (scan)
  );

  // Next state
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      FSM_CLEAR: if (clr_r == ROW_BITS'(ROWS - 1)) fsm_nxt = FSM_IDLE;
      FSM_IDLE:  if (start) fsm_nxt = FSM_EXEC;
      FSM_EXEC:  fsm_nxt = (op_r == OP_SELECT && last_r) ? FSM_CLAIM : FSM_IDLE;
      FSM_CLAIM: fsm_nxt = FSM_IDLE;
      default:   fsm_nxt = FSM_CLEAR;
    endcase
  end

  // Memory control, state update and result
  always_comb begin
    clr_nxt    = clr_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_addr    = row_r;
    cnt_we     = 1'b0;
    st_we      = 1'b0;
    cnt_wdata  = cnt_upd;
    st_wdata   = st_rd_r;
    best_nxt   = best_r;
    ct_nxt     = ct_r;
    res_valid  = 1'b0;
    res_status = RES_ACK;
    res_chosen = '0;
    lane       = pidx_r[2:0];
    ps_old     = '0;
    pidx_use   = ({1'b0, pidx_r} < n_use);
    case (fsm_r)
      FSM_CLEAR: begin
        clr_nxt   = clr_r + 1'b1;
        wr_addr   = clr_r;
        cnt_we    = 1'b1;
        st_we     = 1'b1;
        cnt_wdata = '0;
        st_wdata  = '0;
      end
      FSM_IDLE: begin
        rd_en = accept;
        if (in_opcode <= 3'(OP_SELECT)) begin
          rd_addr = ROW_BITS'(in_byte_index);
        end else begin
          rd_addr = in_piece_index[PIECE_BITS-1:3];
        end
      end
      FSM_EXEC: begin
        ps_old = st_rd_r[lane*PS_BITS +: PS_BITS];
        case (op_r)
          OP_ADD, OP_REMOVE: begin
            cnt_we    = 1'b1;
            res_valid = 1'b1;
          end
          OP_SELECT: begin
            best_nxt = scan;
            if (last_r) begin
              // fetch the winner's state row for the claim
              rd_en   = 1'b1;
              rd_addr = scan.piece[PIECE_BITS-1:3];
            end else begin
              res_valid = 1'b1;
            end
          end
          OP_RELEASE: begin
            res_valid = 1'b1;
            if (pidx_use && ps_old == PS_PROGRESS) begin
              st_we = 1'b1;
              st_wdata[lane*PS_BITS +: PS_BITS] = PS_MISSING;
            end
          end
          OP_DONE: begin
            res_valid = 1'b1;
            if (pidx_use && ps_old != PS_COMPLETE) begin
              st_we  = 1'b1;
              st_wdata[lane*PS_BITS +: PS_BITS] = PS_COMPLETE;
              ct_nxt = ct_r + 1'b1;
            end
          end
          OP_CORRUPT: begin
            res_valid = 1'b1;
            if (pidx_use) begin
              st_we = 1'b1;
              st_wdata[lane*PS_BITS +: PS_BITS] = PS_MISSING;
              if (ps_old == PS_COMPLETE && ct_r != '0) ct_nxt = ct_r - 1'b1;
            end
          end
          default: res_valid = 1'b1;
        endcase
      end
      FSM_CLAIM: begin
        lane      = best_r.piece[2:0];
        ps_old    = st_rd_r[lane*PS_BITS +: PS_BITS];
        wr_addr   = best_r.piece[PIECE_BITS-1:3];
        res_valid = 1'b1;
        best_nxt  = BEST_CLR;
        if (best_r.found && ({1'b0, best_r.piece} < n_use) && ps_old == PS_MISSING) begin
          st_we      = 1'b1;
          st_wdata[lane*PS_BITS +: PS_BITS] = PS_PROGRESS;
          res_status = RES_CHOSEN;
          res_chosen = best_r.piece;
        end else begin
          res_status = RES_NONE;
        end
      end
      default: ;
    endcase
    res_rem = (n_use > ct_nxt) ? (n_use - ct_nxt) : '0;
  end

  // Memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wdata;
    if (rd_en)  cnt_rd_r <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[wr_addr] <= st_wdata;
    if (rd_en) st_rd_r <= st_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= FSM_CLEAR;
      clr_r        <= '0;
      best_r       <= BEST_CLR;
      ct_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      fsm_r        <= fsm_nxt;
      clr_r        <= clr_nxt;
      best_r       <= best_nxt;
      ct_r         <= ct_nxt;
      out_strobe_r <= res_valid;
    end
  end

  // Command capture and result payload; the row is the one read at transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= opcode_t'(in_opcode);
      row_r  <= rd_addr;
      bits_r <= in_bitfield_byte;
      last_r <= in_last_byte;
      pidx_r <= in_piece_index;
    end
    if (res_valid) begin
      out_status_r <= res_status;
      out_chosen_r <= res_chosen;
      out_rem_r    <= res_rem;
      out_done_r   <= (res_rem == '0);
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_status           = out_status_r;
  assign out_chosen_piece     = out_chosen_r;
  assign out_pieces_remaining = out_rem_r;
  assign out_all_done         = out_done_r;

  // Checks
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == FSM_CLEAR) |-> !out_strobe)
    else $error("result strobe during clearing pass");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_opcode == 3'(OP_SELECT) && in_last_byte)) |-> ##2 out_strobe)
    else $error("result missing two cycles after transfer");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe)
    else $error("stray result right after transfer");

  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != 2'(RES_CHOSEN)) |-> (out_chosen_piece == '0))
    else $error("chosen piece set without a claim");

  a_ct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ct_r <= MAX_NUM)
    else $error("completed total beyond piece store");

endmodule

`default_nettype wire

// ===== tb/rarest_first_piece_selector_tb.sv =====
`default_nettype none

module rarest_first_piece_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] PIECE_COUNT_ADDR = 3'd0;
  // opcodes with no function in the block
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int NUM_PHASES = 7;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [2:0]            in_opcode;
  logic [8:0]            in_byte_index;
  logic [7:0]            in_bitfield_byte;
  logic                  in_last_byte;
  logic [PIECE_BITS-1:0] in_piece_index;
  logic                  out_strobe;
  logic [1:0]            out_status;
  logic [PIECE_BITS-1:0] out_chosen_piece;
  logic [NUM_BITS-1:0]   out_pieces_remaining;
  logic                  out_all_done;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  rarest_first_piece_selector DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_byte_index        (in_byte_index),
    .in_bitfield_byte     (in_bitfield_byte),
    .in_last_byte         (in_last_byte),
    .in_piece_index       (in_piece_index),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_chosen_piece     (out_chosen_piece),
    .out_pieces_remaining (out_pieces_remaining),
    .out_all_done         (out_all_done),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // one expected result
  typedef struct {
    logic [1:0]            status;
    logic [PIECE_BITS-1:0] chosen;
    logic [NUM_BITS-1:0]   remaining;
    logic                  all_done;
  } verdict_t;

  // Mirror of the piece stores plus the queue of pending results
  class piece_board;
    logic [COUNT_BITS-1:0] avail [MAX_PIECES];
    pstate_t               pstate [MAX_PIECES];
    logic [NUM_BITS-1:0]   done_total;
    logic [NUM_BITS-1:0]   count_reg;
    logic [BEST_BITS-1:0]  best_cnt;
    logic [PIECE_BITS-1:0] best_pc;
    bit                    best_ok;
    verdict_t              verdict_q[$];
    int                    errors;
    int                    checked;

    function new();
      for (int p = 0; p < MAX_PIECES; p++) begin
        avail[p]  = '0;
        pstate[p] = PS_MISSING;
      end
      done_total = '0;
      count_reg  = NUM_BITS'(1);
      best_cnt   = BEST_RESET;
      best_pc    = '0;
      best_ok    = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_count(logic [NUM_BITS-1:0] value);
      count_reg = value;
    endfunction

    // Predict the result of one accepted command
    function void note_command(logic [2:0] op, logic [8:0] bidx, logic [7:0] bits,
                               logic last, logic [PIECE_BITS-1:0] pidx);
      int       n;
      int       base;
      int       p;
      verdict_t v;
      pstate_t  s;
      n = (count_reg > MAX_NUM) ? MAX_PIECES : int'(count_reg);
      base = int'(bidx) * LANES;
      v.status = RES_ACK;
      v.chosen = '0;
      if (op <= OP_SELECT) begin
        for (int b = 0; b < LANES; b++) begin
          p = base + b;
          if (p < n && bits[7-b]) begin
            if (op == OP_ADD) begin
              if (avail[p] != COUNT_TOP) avail[p] = avail[p] + 1'b1;
            end else if (op == OP_REMOVE) begin
              if (avail[p] != '0) avail[p] = avail[p] - 1'b1;
            end else if (pstate[p] == PS_MISSING &&
                         (!best_ok || {1'b0, avail[p]} < best_cnt)) begin
              best_cnt = {1'b0, avail[p]};
              best_pc  = PIECE_BITS'(p);
              best_ok  = 1;
            end
          end
        end
        // last select byte: claim the winner if it is still eligible
        if (op == OP_SELECT && last) begin
          if (best_ok && int'(best_pc) < n && pstate[best_pc] == PS_MISSING) begin
            pstate[best_pc] = PS_PROGRESS;
            v.status = RES_CHOSEN;
            v.chosen = best_pc;
          end else begin
            v.status = RES_NONE;
          end
          best_cnt = BEST_RESET;
          best_pc  = '0;
          best_ok  = 0;
        end
      end else if (op <= OP_CORRUPT && int'(pidx) < n) begin
        s = pstate[pidx];
        if (op == OP_RELEASE) begin
          if (s == PS_PROGRESS) pstate[pidx] = PS_MISSING;
        end else if (op == OP_DONE) begin
          if (s != PS_COMPLETE) begin
            pstate[pidx] = PS_COMPLETE;
            done_total = done_total + 1'b1;
          end
        end else begin
          if (s == PS_COMPLETE && done_total != '0) done_total = done_total - 1'b1;
          pstate[pidx] = PS_MISSING;
        end
      end
      v.remaining = (n > int'(done_total)) ? NUM_BITS'(n - int'(done_total)) : '0;
      v.all_done  = (v.remaining == '0);
      verdict_q.push_back(v);
    endfunction

    function void match(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(logic [1:0] status, logic [PIECE_BITS-1:0] chosen,
                               logic [NUM_BITS-1:0] remaining, logic all_done);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d piece %0d",
                 $time, status, chosen);
        errors++;
      end else begin
        v = verdict_q.pop_front();
        checked++;
        match("status", int'(v.status), int'(status));
        match("chosen_piece", int'(v.chosen), int'(chosen));
        match("pieces_remaining", int'(v.remaining), int'(remaining));
        match("all_done", int'(v.all_done), int'(all_done));
      end
    endfunction
  endclass

  piece_board          board;
  logic [NUM_BITS-1:0] cur_count;
  int                  gap_pct;
  int                  items_sent;
  int                  settings_used;
  int                  cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rarest_first_piece_selector_tb NOT OK");
      $finish;
    end
  end

  // Monitor: register writes, command transfers and result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == PIECE_COUNT_ADDR)
        board.set_count(pwdata[NUM_BITS-1:0]);
      if (start && !busy)
        board.note_command(in_opcode, in_byte_index, in_bitfield_byte, in_last_byte,
                           in_piece_index);
      if (out_strobe)
        board.check_result(out_status, out_chosen_piece, out_pieces_remaining,
                           out_all_done);
    end
  end

  function automatic int eff_count();
    return (cur_count > MAX_NUM) ? MAX_PIECES : int'(cur_count);
  endfunction

  // Issue one command; start stays high after the transfer
  task automatic send_cmd(input logic [2:0] op, input logic [8:0] bidx,
                          input logic [7:0] bits, input logic last,
                          input logic [PIECE_BITS-1:0] pidx);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    in_opcode        <= op;
    in_byte_index    <= bidx;
    in_bitfield_byte <= bits;
    in_last_byte     <= last;
    in_piece_index   <= pidx;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Stop sending and wait for every pending result
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write of piece_count followed by a read-back
  task automatic cfg_write(input logic [NUM_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PIECE_COUNT_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[NUM_BITS-1:0] !== value) begin
      $display("%0t: piece_count read-back mismatch, expected %0d, actual %0d",
               $time, value, prdata[NUM_BITS-1:0]);
      board.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_count = value;
    settings_used++;
  endtask

  // A run of ascending bitfield bytes for add, remove or select
  task automatic send_sweep(input logic [2:0] op);
    int  nbytes;
    int  first;
    int  len;
    bit  broken;
    nbytes = (eff_count() + LANES - 1) / LANES;
    if (nbytes == 0) nbytes = 1;
    if (nbytes <= 8 && $urandom_range(3) != 0) begin
      first = 0;
      len   = nbytes;
    end else begin
      first = $urandom_range(nbytes - 1);
      len   = $urandom_range(1, 4);
      if (first + len > nbytes) len = nbytes - first;
    end
    broken = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++)
      send_cmd(op, 9'(first + i), 8'($urandom_range(255)),
               (i == len - 1) && !broken, PIECE_BITS'($urandom_range(4095)));
  endtask

  // Random traffic: mostly well-formed sweeps and piece commands, some noise
  task automatic run_phase(input int quota);
    int          stop_at;
    int          r;
    int          n;
    logic [2:0]  op;
    logic [11:0] pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      n = eff_count();
      if (r < 55) begin
        if (r < 20)      send_sweep(OP_ADD);
        else if (r < 28) send_sweep(OP_REMOVE);
        else             send_sweep(OP_SELECT);
      end else if (r < 88) begin
        case ($urandom_range(2))
          0:       op = OP_RELEASE;
          1:       op = OP_DONE;
          default: op = OP_CORRUPT;
        endcase
        if (n == 0 || $urandom_range(9) == 0) pick = 12'($urandom_range(4095));
        else                                  pick = 12'($urandom_range(n - 1));
        send_cmd(op, 9'($urandom_range(511)), 8'($urandom_range(255)),
                 1'($urandom_range(1)), pick);
      end else begin
        send_cmd(3'($urandom_range(7)), 9'($urandom_range(511)),
                 8'($urandom_range(255)), 1'($urandom_range(1)),
                 12'($urandom_range(4095)));
      end
      // occasional full pause until the block has answered everything
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  int phase_count [NUM_PHASES] = '{8, 37, 1, 4096, 24, 64, 5};
  int phase_gap   [NUM_PHASES] = '{0, 51, 0, 32, 51, 0, 32};

  initial begin
    board = new();
    cur_count     = NUM_BITS'(1);
    gap_pct       = 0;
    items_sent    = 0;
    settings_used = 0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_opcode        = '0;
    in_byte_index    = '0;
    in_bitfield_byte = '0;
    in_last_byte     = 1'b0;
    in_piece_index   = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass keeps busy high
    do @(posedge clk); while (busy);

    // directed: reset piece count of one
    send_cmd(OP_ADD, 9'd0, 8'hFF, 1'b1, 12'd0);
    send_cmd(OP_SELECT, 9'd0, 8'hFF, 1'b1, 12'd0);
    send_cmd(OP_DONE, 9'd0, 8'h00, 1'b0, 12'd0);
    send_cmd(OP_DONE, 9'd0, 8'h00, 1'b0, 12'd0);       // counted once
    send_cmd(OP_CORRUPT, 9'd0, 8'h00, 1'b0, 12'd0);    // complete back to missing
    send_cmd(OP_RELEASE, 9'd0, 8'h00, 1'b0, 12'd4095); // piece not in use
    send_cmd(OP_SPARE_LO, 9'd511, 8'hFF, 1'b1, 12'd4095);
    send_cmd(OP_SPARE_HI, 9'd0, 8'h00, 1'b0, 12'd0);
    drain();

    // directed: sixteen pieces, rarest choice, ties and stale winner
    cfg_write(NUM_BITS'(16));
    send_cmd(OP_REMOVE, 9'd1, 8'hFF, 1'b1, 12'd0);     // held at zero
    send_cmd(OP_ADD, 9'd0, 8'h81, 1'b0, 12'd0);
    send_cmd(OP_ADD, 9'd1, 8'hFF, 1'b1, 12'd0);
    send_cmd(OP_SELECT, 9'd0, 8'hFF, 1'b0, 12'd0);
    send_cmd(OP_SELECT, 9'd1, 8'hFF, 1'b1, 12'd0);
    send_cmd(OP_SELECT, 9'd0, 8'h20, 1'b0, 12'd0);
    send_cmd(OP_DONE, 9'd0, 8'h00, 1'b0, 12'd2);       // winner goes stale
    send_cmd(OP_SELECT, 9'd1, 8'h00, 1'b1, 12'd0);
    send_cmd(OP_RELEASE, 9'd0, 8'h00, 1'b0, 12'd1);
    send_cmd(OP_RELEASE, 9'd0, 8'h00, 1'b0, 12'd3);    // missing stays missing
    send_cmd(OP_SELECT, 9'd0, 8'h40, 1'b1, 12'd0);
    send_cmd(OP_CORRUPT, 9'd0, 8'h00, 1'b0, 12'd1);
    send_cmd(OP_CORRUPT, 9'd0, 8'h00, 1'b0, 12'd2);
    drain();

    // directed: full size and the top byte
    cfg_write(MAX_NUM);
    send_cmd(OP_ADD, 9'd511, 8'hFF, 1'b1, 12'd0);
    send_cmd(OP_SELECT, 9'd511, 8'h01, 1'b1, 12'd0);
    send_cmd(OP_DONE, 9'd0, 8'h00, 1'b0, 12'd4095);
    drain();
    // count above the store size is limited
    cfg_write(NUM_BITS'(8191));
    send_cmd(OP_SELECT, 9'd511, 8'hFF, 1'b1, 12'd0);
    drain();
    // no pieces in use
    cfg_write(NUM_BITS'(0));
    send_cmd(OP_DONE, 9'd0, 8'h00, 1'b0, 12'd0);
    drain();
    // shrunk down to the completed total
    cfg_write(NUM_BITS'(1));
    send_cmd(OP_SPARE_LO, 9'd0, 8'h00, 1'b0, 12'd0);
    drain();

    // random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cfg_write(NUM_BITS'(phase_count[ph]));
      gap_pct = phase_gap[ph];
      run_phase(150);
      drain();
    end

    if (board.verdict_q.size() != 0) begin
      $display("%0t: results outstanding, expected 0, actual %0d", $time,
               board.verdict_q.size());
      board.errors++;
    end
    $display("Sent %0d commands under %0d piece-count settings, %0d results compared.",
             items_sent, settings_used, board.checked);
    $display("Covered add/remove sweeps, rarest-first selects, state changes and noise.");
    if (board.errors == 0) begin
      $display("rarest_first_piece_selector_tb OK");
    end else begin
      $display("rarest_first_piece_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rarest_first_piece_selector.f =====
rtl/core/rfps_pkg.sv
rtl/core/rfps_row_unit.sv
rtl/core/rarest_first_piece_selector.sv
tb/rarest_first_piece_selector_tb.sv
